### design/sbrd_pkg.sv
// Shared constants, field widths and word types of the bear regime detector.
// No dependencies; imported by every module of the block but sbrd_ram.
`timescale 1ns / 1ps

package sbrd_pkg;

  localparam int WINDOW     = 200;
  localparam int PRICE_W    = 32;
  localparam int TS_W       = 48;
  localparam int CNT_W      = 8;
  localparam int PTR_W      = $clog2(WINDOW);
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int SUM_W      = PRICE_W + $clog2(WINDOW);
  localparam int DAY_W      = 22;
  localparam longint MS_PER_DAY = 64'd86400000;

  // day = (ts >> 10) / 84375, done as a multiply by ceil(2**55 / 84375)
  localparam int DAY_LOG2_MS = 10;
  localparam int DAYX_W      = TS_W - DAY_LOG2_MS;
  localparam int RECIP_W     = 39;
  localparam int RECIP_SH    = 55;
  localparam logic [RECIP_W-1:0] DAY_RECIP = 39'd427007964670;
  localparam int SPLIT_W     = 19;
  localparam int PP_W        = DAYX_W + RECIP_W - 2 * SPLIT_W;
  localparam int PROD_W      = DAYX_W + RECIP_W;

  localparam int LINK_DEPTH = 4;
  localparam int LINK_PTR_W = $clog2(LINK_DEPTH);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

  localparam logic [CNT_W-1:0] RUN_MAX         = 8'd255;
  localparam logic [CNT_W-1:0] BEAR_DAYS_RESET = 8'd20;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEED = 1'b1
  } op_e;

  typedef enum logic {
    REG_BEAR_DAYS = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic               roll;
    logic [PRICE_W-1:0] close;
  } link_word_t;

  typedef struct packed {
    logic             bear;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             rolled;
  } result_t;

endpackage

### design/sbrd_ram.sv
// Generic single-port-pair RAM, one write and one registered read per cycle.
// Read-first on a same-address write. No dependencies.
`timescale 1ns / 1ps

module sbrd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 200,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sbrd_front.sv
// Front end: pipelined day-number reciprocal multiply and tick/day classifier.
// Depends on sbrd_pkg; emits link words of roll flag and daily close.
`timescale 1ns / 1ps

module sbrd_front import sbrd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               operation_i,
  input  logic [TS_W-1:0]    timestamp_ms_i,
  input  logic [PRICE_W-1:0] price_i,
  output logic               word_valid_o,
  output link_word_t         word_o,
  input  logic               word_full_i
);

  logic               v0_q, v1_q, v2_q;
  logic [DAYX_W-1:0]  x_q;
  logic [PP_W-1:0]    pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [PROD_W-1:0]  prod;
  logic [DAY_W-1:0]   quo_q;
  logic               op0_q, op1_q, op2_q;
  logic [PRICE_W-1:0] px0_q, px1_q, px2_q;

  logic               adv;
  logic               take;
  logic               started_q, started_d;
  logic [DAY_W-1:0]   day_q, day_d;
  logic [PRICE_W-1:0] last_q, last_d;

  assign adv    = !(v2_q && word_full_i);
  assign full_o = !adv;
  assign take   = v2_q && !word_full_i;

  assign prod = (PROD_W'(pp_hh_q) << (2 * SPLIT_W))
              + ((PROD_W'(pp_hl_q) + PROD_W'(pp_lh_q)) << SPLIT_W)
              + PROD_W'(pp_ll_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v0_q <= push_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q     <= timestamp_ms_i[TS_W-1:DAY_LOG2_MS];
      op0_q   <= operation_i;
      px0_q   <= price_i;
      pp_hh_q <= PP_W'(x_q[DAYX_W-1:SPLIT_W]) * PP_W'(DAY_RECIP[RECIP_W-1:SPLIT_W]);
      pp_hl_q <= PP_W'(x_q[DAYX_W-1:SPLIT_W]) * PP_W'(DAY_RECIP[SPLIT_W-1:0]);
      pp_lh_q <= PP_W'(x_q[SPLIT_W-1:0]) * PP_W'(DAY_RECIP[RECIP_W-1:SPLIT_W]);
      pp_ll_q <= PP_W'(x_q[SPLIT_W-1:0]) * PP_W'(DAY_RECIP[SPLIT_W-1:0]);
      op1_q   <= op0_q;
      px1_q   <= px0_q;
      quo_q   <= prod[PROD_W-1:RECIP_SH];
      op2_q   <= op1_q;
      px2_q   <= px1_q;
    end
  end

  always_comb begin
    started_d  = started_q;
    day_d      = day_q;
    last_d     = last_q;
    word_o     = '{roll: 1'b0, close: last_q};
    unique case (op_e'(op2_q))
      OP_SEED: begin
        word_o = '{roll: 1'b1, close: px2_q};
      end
      OP_TICK: begin
        word_o.roll = started_q && (quo_q != day_q);
        if (take) begin
          started_d = 1'b1;
          day_d     = quo_q;
          last_d    = px2_q;
        end
      end
      default: begin
        word_o = '{roll: 1'b0, close: last_q};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      day_q     <= '0;
      last_q    <= '0;
    end else begin
      started_q <= started_d;
      day_q     <= day_d;
      last_q    <= last_d;
    end
  end

  assign word_valid_o = v2_q;

endmodule

### design/sbrd_link.sv
// Short word queue between the front classifier and the window back end.
// Depends on sbrd_pkg for the link word type and depth.
`timescale 1ns / 1ps

module sbrd_link import sbrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  input  link_word_t wr_word_i,
  output logic       full_o,
  output logic       valid_o,
  output link_word_t word_o,
  input  logic       rd_i
);

  link_word_t            mem_q [LINK_DEPTH];
  logic [LINK_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LINK_PTR_W:0]   cnt_q;
  logic                  wr, rd;

  assign full_o  = (cnt_q == (LINK_PTR_W + 1)'(LINK_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign wr      = wr_valid_i && !full_o;
  assign rd      = rd_i && valid_o;
  assign word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= wr_ptr_q + LINK_PTR_W'(1);
      end
      if (rd) begin
        rd_ptr_q <= rd_ptr_q + LINK_PTR_W'(1);
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + (LINK_PTR_W + 1)'(1);
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - (LINK_PTR_W + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (LINK_PTR_W + 1)'(LINK_DEPTH))
    else $error("link queue count out of range");

endmodule

### design/sbrd_back.sv
// Back end: close ring, running sum, bear run counter and result queue.
// Depends on sbrd_pkg and sbrd_ram.
`timescale 1ns / 1ps

module sbrd_back import sbrd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_valid_i,
  input  link_word_t       word_i,
  output logic             word_pop_o,
  input  logic [CNT_W-1:0] bear_days_i,
  output logic             empty_o,
  input  logic             pop_i,
  output result_t          result_o
);

  logic               adv, pop_a, was_full_a, full_a;
  logic [FILL_W-1:0]  fill_q;
  logic [PTR_W-1:0]   wp_q;
  logic [PRICE_W-1:0] old_close;

  logic               vb_q, roll_b_q, was_full_b_q, full_b_q;
  logic [PRICE_W-1:0] close_b_q;
  logic [SUM_W-1:0]   prod_b_q;
  logic [SUM_W-1:0]   sum_q, sum_d;

  logic               vc_q, roll_c_q, full_c_q;
  logic [SUM_W-1:0]   prod_c_q, sum_c_q, prev_q, prev_d;
  logic [CNT_W-1:0]   run_q, run_d;
  logic               bear_q, bear_d, bearish;

  result_t                oq_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  oq_wr_q, oq_rd_q;
  logic [OUTQ_PTR_W:0]    oq_cnt_q;
  logic                   oq_full, oq_wr, oq_rd;

  assign oq_full    = (oq_cnt_q == (OUTQ_PTR_W + 1)'(OUTQ_DEPTH));
  assign adv        = !(vc_q && oq_full);
  assign pop_a      = word_valid_i && adv;
  assign word_pop_o = pop_a;
  assign was_full_a = (fill_q == FILL_W'(WINDOW));
  assign full_a     = was_full_a || (word_i.roll && (fill_q == FILL_W'(WINDOW - 1)));

  sbrd_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (pop_a && word_i.roll),
    .waddr_i (wp_q),
    .wdata_i (word_i.close),
    .re_i    (pop_a && word_i.roll),
    .raddr_i (wp_q),
    .rdata_o (old_close)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wp_q   <= '0;
    end else if (pop_a && word_i.roll) begin
      if (!was_full_a) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      wp_q <= (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (vb_q && roll_b_q) begin
      if (was_full_b_q) begin
        sum_d = sum_q - SUM_W'(old_close) + SUM_W'(close_b_q);
      end else begin
        sum_d = sum_q + SUM_W'(close_b_q);
      end
    end
  end

  always_comb begin
    bearish = (prev_q != '0) && (prod_c_q < sum_c_q) && (sum_c_q < prev_q);
    run_d   = run_q;
    bear_d  = bear_q;
    prev_d  = prev_q;
    if (vc_q && roll_c_q && full_c_q) begin
      if (bearish) begin
        run_d = (run_q == RUN_MAX) ? run_q : run_q + CNT_W'(1);
      end else begin
        run_d = '0;
      end
      bear_d = (run_d >= bear_days_i);
      prev_d = sum_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      sum_q  <= '0;
      prev_q <= '0;
      run_q  <= '0;
      bear_q <= 1'b0;
    end else if (adv) begin
      vb_q   <= pop_a;
      vc_q   <= vb_q;
      sum_q  <= sum_d;
      prev_q <= prev_d;
      run_q  <= run_d;
      bear_q <= bear_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_b_q     <= word_i.roll;
      close_b_q    <= word_i.close;
      prod_b_q     <= SUM_W'(word_i.close) * SUM_W'(WINDOW);
      was_full_b_q <= was_full_a;
      full_b_q     <= full_a;
      roll_c_q     <= roll_b_q;
      full_c_q     <= full_b_q;
      prod_c_q     <= prod_b_q;
      sum_c_q      <= sum_d;
    end
  end

  assign oq_wr = vc_q && !oq_full;
  assign oq_rd = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (oq_wr) begin
      oq_q[oq_wr_q] <= '{bear: bear_d, count: run_d, full: full_c_q, rolled: roll_c_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_wr) begin
        oq_wr_q <= oq_wr_q + OUTQ_PTR_W'(1);
      end
      if (oq_rd) begin
        oq_rd_q <= oq_rd_q + OUTQ_PTR_W'(1);
      end
      if (oq_wr && !oq_rd) begin
        oq_cnt_q <= oq_cnt_q + (OUTQ_PTR_W + 1)'(1);
      end else if (oq_rd && !oq_wr) begin
        oq_cnt_q <= oq_cnt_q - (OUTQ_PTR_W + 1)'(1);
      end
    end
  end

  assign empty_o  = (oq_cnt_q == '0);
  assign result_o = oq_q[oq_rd_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW))
    else $error("fill count beyond window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < PTR_W'(WINDOW))
    else $error("write pointer beyond window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_a && word_i.roll) |=> (wp_q != $past(wp_q)))
    else $error("write pointer held on a close push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= (OUTQ_PTR_W + 1)'(OUTQ_DEPTH))
    else $error("result queue count out of range");

endmodule

### design/sustained_bear_regime_detector.sv
// Top level of the sustained bear regime detector: config register and wiring.
// Depends on sbrd_pkg, sbrd_front, sbrd_link, sbrd_back (and sbrd_ram below it).
//
//   channel   handshake                  payload
//   input     push / full                operation_i, timestamp_ms_i, price_i
//   result    empty / pop                bear_flag_o, bear_day_count_o, window_full_o,
//                                        day_rolled_o
//   config    psel penable pwrite pready paddr, pwdata, prdata (bear_days_needed at 0)
//
// One word in and one result out per cycle, sustained, while the result side pops every result.
// A result passes, after the edge that takes its word, through 2 more front stages (partial
// products of the day-number reciprocal multiply, then sum and shift), the link queue,
// the ring read, the sum and compare stage, and the result queue.
// Reset is asynchronous and active low; the close ring needs no clearing pass.
// A stall on the result side backs up through the back end, the link queue and the front.
`timescale 1ns / 1ps

module sustained_bear_regime_detector import sbrd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  operation_i,
  input  logic [TS_W-1:0]       timestamp_ms_i,
  input  logic [PRICE_W-1:0]    price_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  bear_flag_o,
  output logic [CNT_W-1:0]      bear_day_count_o,
  output logic                  window_full_o,
  output logic                  day_rolled_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic             sel_bear_days;
  logic [CNT_W-1:0] needed_q;
  logic             front_valid, link_full, link_valid, link_pop;
  link_word_t       front_word, link_word;
  result_t          result;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needed_q <= BEAR_DAYS_RESET;
    end else if (psel && penable && pwrite && pready && sel_bear_days) begin
      needed_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    sel_bear_days = 1'b0;
    prdata        = '0;
    unique case (reg_idx_e'(paddr[2]))
      REG_BEAR_DAYS: begin
        sel_bear_days = 1'b1;
        prdata        = APB_DATA_W'(needed_q);
      end
      default: begin
        sel_bear_days = 1'b0;
        prdata        = '0;
      end
    endcase
  end

  sbrd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .operation_i    (operation_i),
    .timestamp_ms_i (timestamp_ms_i),
    .price_i        (price_i),
    .word_valid_o   (front_valid),
    .word_o         (front_word),
    .word_full_i    (link_full)
  );

  sbrd_link u_link (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_word_i  (front_word),
    .full_o     (link_full),
    .valid_o    (link_valid),
    .word_o     (link_word),
    .rd_i       (link_pop)
  );

  sbrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (link_valid),
    .word_i       (link_word),
    .word_pop_o   (link_pop),
    .bear_days_i  (needed_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result)
  );

  assign bear_flag_o      = result.bear;
  assign bear_day_count_o = result.count;
  assign window_full_o    = result.full;
  assign day_rolled_o     = result.rolled;

endmodule

### dv/sbrd_regime_checker.sv
// Checker for the bear regime detector: predicts one result per accepted word and
// compares it with the result channel. Depends on sbrd_pkg only.
`timescale 1ns / 1ps

module sbrd_regime_checker import sbrd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  logic                  operation_i,
  input  logic [TS_W-1:0]       timestamp_ms_i,
  input  logic [PRICE_W-1:0]    price_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic                  bear_flag_o,
  input  logic [CNT_W-1:0]      bear_day_count_o,
  input  logic                  window_full_o,
  input  logic                  day_rolled_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    bear_hits,
  output int                    peak_run
);

  localparam int DUE_DEPTH = 64;

  logic [PRICE_W-1:0] close_ring [WINDOW];
  int unsigned        ring_wr;
  int unsigned        ring_fill;
  logic [63:0]        sum_now;
  logic [63:0]        sum_prev;
  logic [CNT_W-1:0]   run_len;
  logic [CNT_W-1:0]   days_needed;
  logic               bear_now;
  logic               day_open;
  logic [31:0]        day_now;
  logic [PRICE_W-1:0] last_tick_px;
  result_t            regime_due_q [DUE_DEPTH];
  int                 due_rd;
  int                 due_wr;
  int                 due_cnt;

  function automatic void push_close(input logic [PRICE_W-1:0] close);
    if (ring_fill < WINDOW) begin
      sum_now = sum_now + 64'(close);
      ring_fill++;
    end else begin
      sum_now = sum_now - 64'(close_ring[ring_wr]) + 64'(close);
    end
    close_ring[ring_wr] = close;
    ring_wr = (ring_wr + 1 >= WINDOW) ? 0 : ring_wr + 1;
    if (ring_fill < WINDOW) begin
      sum_prev = '0;
      return;
    end
    if (sum_prev != 0 && 64'(WINDOW) * 64'(close) < sum_now && sum_now < sum_prev) begin
      if (run_len != RUN_MAX) run_len++;
    end else begin
      run_len = '0;
    end
    bear_now = (run_len >= days_needed);
    sum_prev = sum_now;
  endfunction

  function automatic result_t step_regime(input op_e op, input logic [TS_W-1:0] ts,
                                          input logic [PRICE_W-1:0] px);
    logic [31:0] day;
    logic        rolled;
    result_t     res;
    rolled = 1'b0;
    day = 32'(64'(ts) / MS_PER_DAY);
    if (op == OP_SEED) begin
      push_close(px);
      rolled = 1'b1;
    end else begin
      if (!day_open) begin
        day_open = 1'b1;
        day_now = day;
      end else if (day != day_now) begin
        push_close(last_tick_px);
        day_now = day;
        rolled = 1'b1;
      end
      last_tick_px = px;
    end
    res.bear   = bear_now;
    res.count  = run_len;
    res.full   = (ring_fill >= WINDOW);
    res.rolled = rolled;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      ring_wr = 0;
      ring_fill = 0;
      sum_now = '0;
      sum_prev = '0;
      run_len = '0;
      days_needed = BEAR_DAYS_RESET;
      bear_now = 1'b0;
      day_open = 1'b0;
      day_now = '0;
      last_tick_px = '0;
      due_rd = 0;
      due_wr = 0;
      due_cnt = 0;
      pending = 0;
    end else begin
      if (!empty && pop) begin
        if (due_cnt == 0) begin
          $error("result word with no word outstanding");
          fail_count++;
        end else begin
          want = regime_due_q[due_rd];
          due_rd = (due_rd + 1) % DUE_DEPTH;
          due_cnt--;
          got.bear   = bear_flag_o;
          got.count  = bear_day_count_o;
          got.full   = window_full_o;
          got.rolled = day_rolled_o;
          if (got.bear !== want.bear) begin
            $error("bear_flag: expected %0d, got %0d", want.bear, got.bear);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("bear_day_count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
          if (got.full !== want.full) begin
            $error("window_full: expected %0d, got %0d", want.full, got.full);
            fail_count++;
          end
          if (got.rolled !== want.rolled) begin
            $error("day_rolled: expected %0d, got %0d", want.rolled, got.rolled);
            fail_count++;
          end
          checked++;
          if (want.bear) bear_hits++;
        end
      end
      if (push && !full) begin
        want = step_regime(op_e'(operation_i), timestamp_ms_i, price_i);
        if (due_cnt == DUE_DEPTH) begin
          $error("more words outstanding than the checker can hold");
          fail_count++;
        end else begin
          regime_due_q[due_wr] = want;
          due_wr = (due_wr + 1) % DUE_DEPTH;
          due_cnt++;
        end
        if (int'(want.count) > peak_run) peak_run = int'(want.count);
      end
      if (psel && penable && pwrite && pready &&
          reg_idx_e'(paddr[APB_ADDR_W-1:2]) == REG_BEAR_DAYS) begin
        days_needed = pwdata[CNT_W-1:0];
      end
      pending = due_cnt;
    end
  end

endmodule

### dv/sustained_bear_regime_detector_tb.sv
// Testbench top for the bear regime detector: clock, reset, stimulus and verdict.
// Depends on sbrd_pkg, sustained_bear_regime_detector and sbrd_regime_checker.
`timescale 1ns / 1ps

module sustained_bear_regime_detector_tb;
  import sbrd_pkg::*;

  localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          LONG_HOLD     = 150;
  localparam logic [APB_ADDR_W-1:0] BEAR_DAYS_ADDR = {REG_BEAR_DAYS, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR     = BEAR_DAYS_ADDR + 3'd4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic                  operation_i;
  logic [TS_W-1:0]       timestamp_ms_i;
  logic [PRICE_W-1:0]    price_i;
  logic                  empty;
  logic                  pop;
  logic                  bear_flag_o;
  logic [CNT_W-1:0]      bear_day_count_o;
  logic                  window_full_o;
  logic                  day_rolled_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int checked;
  int bear_hits;
  int peak_run;

  int          burst_left;
  int          words_sent;
  int          settings_used;
  int          holds_requested;
  int          holds_served;
  int          pop_pct;
  int          pattern_left;
  logic [31:0] seed_level;
  int unsigned tick_day;
  longint      tick_level;

  sustained_bear_regime_detector uut (.*);

  sbrd_regime_checker checker_i (.*);

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_word(input op_e op, input logic [TS_W-1:0] ts,
                           input logic [PRICE_W-1:0] px);
    operation_i = op;
    timestamp_ms_i = ts;
    price_i = px;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    words_sent++;
    @(negedge clk_i);
    push = 1'b0;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic drain_results();
    push = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_bear_days(input logic [CNT_W-1:0] days,
                               input logic [APB_ADDR_W-1:0] addr);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = {24'($urandom), days};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == BEAR_DAYS_ADDR) settings_used++;
  endtask

  // strictly falling daily closes: every day bearish once the window holds only them
  task automatic send_falling_seeds(input int count);
    repeat (count) begin
      seed_level = seed_level - $urandom_range(1, 32'h0010_0000);
      send_word(OP_SEED, 48'({$urandom, $urandom}), seed_level);
    end
  endtask

  task automatic send_tick_days(input int count, input int drift);
    int     sent;
    int     per_day;
    longint offset;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 19))
        0:       tick_day = tick_day - $urandom_range(1, 5);
        1:       tick_day = tick_day + $urandom_range(2, 30);
        default: tick_day = tick_day + 1;
      endcase
      per_day = $urandom_range(1, 4);
      while (per_day > 0 && sent < count) begin
        tick_level = tick_level - drift + longint'($urandom_range(0, 600000)) - 300000;
        if (tick_level < 64'h1000_0000 || tick_level > 64'hF000_0000)
          tick_level = 64'hC000_0000;
        offset = longint'($urandom_range(0, 86399999));
        send_word(OP_TICK, 48'(longint'(tick_day) * MS_PER_DAY + offset), 32'(tick_level));
        per_day--;
        sent++;
      end
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) begin
      send_word(op_e'($urandom_range(0, 1)), 48'({$urandom, $urandom}), $urandom);
    end
  endtask

  // receiver: random pop pattern, plus long holds on request
  initial begin
    pop = 1'b0;
    pop_pct = 100;
    pattern_left = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_requested) begin
        pop = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        holds_served++;
      end
      if (pattern_left <= 0) begin
        case ($urandom_range(0, 4))
          0, 1:    pop_pct = 100;
          2:       pop_pct = 70;
          3:       pop_pct = 40;
          default: pop_pct = 15;
        endcase
        pattern_left = $urandom_range(20, 150);
      end
      pattern_left--;
      pop = ($urandom_range(1, 100) <= pop_pct);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    operation_i = OP_TICK;
    timestamp_ms_i = '0;
    price_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = $urandom_range(1, 40);
    words_sent = 0;
    settings_used = 0;
    holds_requested = 0;
    holds_served = 0;
    seed_level = 32'hF000_0000;
    tick_day = 19000;
    tick_level = 64'hC000_0000;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first tick, same-day tick, roll, far future, time going backwards, seeds
    send_word(OP_TICK, '0, '0);
    send_word(OP_TICK, 48'(MS_PER_DAY - 1), 32'hFFFF_FFFF);
    send_word(OP_TICK, 48'(MS_PER_DAY), 32'h0000_0001);
    send_word(OP_TICK, 48'hFFFF_FFFF_FFFF, 32'h5555_5555);
    send_word(OP_TICK, '0, 32'hAAAA_AAAA);
    send_word(OP_TICK, 48'd1, '0);
    send_word(OP_SEED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_SEED, '0, '0);
    send_word(OP_SEED, 48'h5555_5555_5555, 32'h1234_5678);
    send_word(OP_TICK, 48'hAAAA_AAAA_AAAA, 32'h8000_0000);
    send_word(OP_TICK, 48'hAAAA_AAAA_AAAB, 32'h7FFF_FFFF);
    send_word(OP_TICK, 48'h5555_5555_5555, 32'hFFFF_FFFF);

    // fill the window with falling closes, then run into saturation
    drain_results();
    set_bear_days(8'd1, BEAR_DAYS_ADDR);
    send_falling_seeds(230);
    drain_results();
    set_bear_days(8'd255, BEAR_DAYS_ADDR);
    holds_requested++;
    send_falling_seeds(270);

    drain_results();
    set_bear_days(8'd0, BEAR_DAYS_ADDR);
    send_tick_days(300, 200000);
    drain_results();
    set_bear_days(8'($urandom_range(2, 30)), BEAR_DAYS_ADDR);
    holds_requested++;
    send_tick_days(300, 600000);

    drain_results();
    set_bear_days(BEAR_DAYS_RESET, BEAR_DAYS_ADDR);
    send_noise(150);
    drain_results();
    set_bear_days(8'($urandom_range(3, 10)), BEAR_DAYS_ADDR);
    set_bear_days(8'($urandom), SPARE_ADDR);
    send_falling_seeds(100);
    send_noise(50);
    send_tick_days(40, 400000);

    drain_results();
    $display("Covered %0d words and %0d checked results, %0d of them under the bear flag.",
             words_sent, checked, bear_hits);
    $display("Deepest bearish run %0d, %0d threshold settings, %0d long receiver holds.",
             peak_run, settings_used, holds_served);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
